FILE: design/csspan_pkg.sv
// Shared types, constants and square-root step for the circle scanline span block.
package csspan_pkg;

	// Radius saturation and fixed-point format
	localparam logic [11:0] RADIUS_MAX       = 12'd4000;
	localparam int          RADIUS_FRAC_BITS = 4;

	// Square root of a 16-bit radicand: 8 result digits, two per stage
	localparam int RADICAND_W       = 16;
	localparam int ROOT_W           = 8;
	localparam int REM_W            = 9;
	localparam int DIGITS_PER_STAGE = 2;
	localparam int SQRT_STAGES      = ROOT_W / DIGITS_PER_STAGE;

	typedef struct packed {
		logic [11:0] radius_sixteenths;
		logic [7:0]  center_x;
		logic [7:0]  center_y;
		logic [7:0]  line;
	} span_req_t;

	typedef struct packed {
		logic [7:0] left_edge;
		logic [7:0] right_edge;
	} span_rsp_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_acc_t;

	// One digit of the restoring square root: bring in two radicand bits
	function automatic sqrt_acc_t sqrt_digit(input sqrt_acc_t acc, input logic [1:0] pair);
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		sqrt_acc_t        nxt;
		cur   = {acc.rem, pair};
		trial = {1'b0, acc.root, 2'b01};
		if (cur >= trial) begin
			nxt.rem  = REM_W'(cur - trial);
			nxt.root = {acc.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(cur);
			nxt.root = {acc.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

FILE: design/circle_scanline_span.sv
// Circle scanline span: left and right window edges of a filled circle on one line.
//
// Usage: present one request per cycle on req with req_valid; it is taken at a
// rising edge where req_valid is high and req_stall is low. Each request gives
// the radius in 1/16 pixel, the circle center and the scanline. One response
// per request comes out on rsp/rsp_valid, in request order, and is taken at an
// edge where rsp_valid is high and rsp_stall is low.
// From request to response the pipeline registers decode, the two squares, their
// difference, four square-root stages of two digits each, and the edge clamp.
// Throughput is one request per cycle but for stalls; requests are independent.
// The pipeline advances as a whole: while a response waits under rsp_stall,
// req_stall is raised and every stage holds. Empty stages carry no valid bit,
// so bubbles never raise rsp_valid.
// Reset clears all valid bits; the pipeline is empty and takes a request in
// the first cycle after reset is released.
module circle_scanline_span #(
	parameter int SCREEN_LINES = 180,
	parameter int SCREEN_WIDTH = 240
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  csspan_pkg::span_req_t req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output csspan_pkg::span_rsp_t rsp
);
	import csspan_pkg::*;

	localparam logic [8:0] LAST_LINE   = 9'(SCREEN_LINES - 1);
	localparam logic [8:0] RIGHT_LIMIT = 9'(SCREEN_WIDTH);

	logic advance;

	// Hold the whole pipeline while a response is stalled
	assign advance   = !(rsp_valid && rsp_stall);
	assign req_stall = !advance;

	// Stage 1: saturate radius, test line coverage, distance to center line
	logic [11:0] rad_sat;
	logic [7:0]  r_px;
	logic [9:0]  line_plus_r;
	logic [9:0]  cy_plus_r;
	logic        covered;
	logic [7:0]  dy_abs;

	always_comb begin
		rad_sat     = (req.radius_sixteenths > RADIUS_MAX) ? RADIUS_MAX : req.radius_sixteenths;
		r_px        = 8'(rad_sat >> RADIUS_FRAC_BITS);
		line_plus_r = {2'b00, req.line} + {2'b00, r_px};
		cy_plus_r   = {2'b00, req.center_y} + {2'b00, r_px};
		covered     = ({1'b0, req.line} < LAST_LINE)
			&& (line_plus_r >= {2'b00, req.center_y})
			&& ({2'b00, req.line} < cy_plus_r);
		dy_abs      = (req.center_y >= req.line) ? (req.center_y - req.line)
			: (req.line - req.center_y);
	end

	logic       valid_s1;
	logic       covered_s1;
	logic [7:0] r_s1;
	logic [7:0] dy_s1;
	logic [7:0] cx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			covered_s1 <= covered;
			r_s1       <= r_px;
			dy_s1      <= dy_abs;
			cx_s1      <= req.center_x;
		end
	end

	// Stage 2: square radius and distance
	logic        valid_s2;
	logic        covered_s2;
	logic [15:0] r_sq_s2;
	logic [15:0] dy_sq_s2;
	logic [7:0]  cx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			covered_s2 <= covered_s1;
			r_sq_s2    <= r_s1 * r_s1;
			dy_sq_s2   <= dy_s1 * dy_s1;
			cx_s2      <= cx_s1;
		end
	end

	// Stage 3: radicand, forced to zero on uncovered lines
	logic                  valid_s3;
	logic                  covered_s3;
	logic [RADICAND_W-1:0] radicand_s3;
	logic [7:0]            cx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			covered_s3  <= covered_s2;
			radicand_s3 <= covered_s2 ? (r_sq_s2 - dy_sq_s2) : '0;
			cx_s3       <= cx_s2;
		end
	end

	// Square-root stages: two digits each, radicand shifts out from the top
	logic                  valid_sq_s   [SQRT_STAGES+1];
	logic                  covered_sq_s [SQRT_STAGES+1];
	logic [RADICAND_W-1:0] rad_sq_s     [SQRT_STAGES+1];
	sqrt_acc_t             acc_sq_s     [SQRT_STAGES+1];
	logic [7:0]            cx_sq_s      [SQRT_STAGES+1];

	assign valid_sq_s[0]   = valid_s3;
	assign covered_sq_s[0] = covered_s3;
	assign rad_sq_s[0]     = radicand_s3;
	assign acc_sq_s[0]     = '0;
	assign cx_sq_s[0]      = cx_s3;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		sqrt_acc_t acc_mid;
		sqrt_acc_t acc_nxt;

		// Resolve two root digits
		always_comb begin
			acc_mid = sqrt_digit(acc_sq_s[k], rad_sq_s[k][RADICAND_W-1 -: 2]);
			acc_nxt = sqrt_digit(acc_mid, rad_sq_s[k][RADICAND_W-3 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sq_s[k+1] <= 1'b0;
			end else if (advance) begin
				valid_sq_s[k+1] <= valid_sq_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				covered_sq_s[k+1] <= covered_sq_s[k];
				rad_sq_s[k+1]     <= {rad_sq_s[k][RADICAND_W-5:0], 4'b0000};
				acc_sq_s[k+1]     <= acc_nxt;
				cx_sq_s[k+1]      <= cx_sq_s[k];
			end
		end
	end

	// Final stage: clamp edges to the screen and zero the edges of uncovered lines
	logic [ROOT_W-1:0] half;
	logic [7:0]        cx_f;
	logic [8:0]        right_sum;
	logic [7:0]        left_nxt;
	logic [7:0]        right_nxt;

	always_comb begin
		half      = acc_sq_s[SQRT_STAGES].root;
		cx_f      = cx_sq_s[SQRT_STAGES];
		right_sum = {1'b0, cx_f} + {1'b0, half};
		left_nxt  = (cx_f >= half) ? (cx_f - half) : 8'd0;
		right_nxt = (right_sum > RIGHT_LIMIT) ? RIGHT_LIMIT[7:0] : right_sum[7:0];
		if (!covered_sq_s[SQRT_STAGES]) begin
			left_nxt  = 8'd0;
			right_nxt = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_sq_s[SQRT_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.left_edge  <= left_nxt;
			rsp.right_edge <= right_nxt;
		end
	end

endmodule
